/* rtl/rcsfd_pkg.sv */
`default_nettype none

package rcsfd_pkg;

   // frame layout
   localparam int unsigned BODY_BYTES   = 24;
   localparam int unsigned ADDR_W       = 5;
   localparam int unsigned CHAN_W       = 11;
   localparam int unsigned CHAN_IDX_W   = 4;
   localparam int unsigned CSR_INDEX_W  = 3;

   localparam logic [ADDR_W-1:0]     LAST_SLOT      = 5'd23;
   localparam logic [ADDR_W-1:0]     FLAGS_ADDR     = 5'd22;
   localparam logic [ADDR_W-1:0]     LAST_DATA_ADDR = 5'd21;
   localparam logic [CHAN_IDX_W-1:0] LAST_CHAN      = 4'd15;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_HEADER     = 3'd0,
      REG_FOOTER     = 3'd1,
      REG_ALT_MASK   = 3'd2,
      REG_ALT_VALUE  = 3'd3,
      REG_LOST_MASK  = 3'd4,
      REG_SAFE_MASK  = 3'd5
   } csr_reg_type;

   // sequencer to unpacker
   typedef struct packed {
      logic clear;
      logic byte_valid;
      logic lost;
      logic safe;
   } unp_ctrl_type;

   // unpacker to sequencer
   typedef struct packed {
      logic byte_ready;
   } unp_stat_type;

endpackage

`default_nettype wire

/* rtl/rc_servo_frame_decoder_unit.sv */
`default_nettype none

// Serial-bus servo frame decoder. One received byte is taken per word on the
// req channel while hunting for a header or collecting a frame. A header
// counts only when the byte before it is a footer (plain or masked alternate).
// The 24 bytes after it go into a small frame memory; if the last is a footer,
// the block stalls req and walks the memory: it reads the flags byte, then
// feeds one stored byte per cycle through an 11-bit unpacker while the rsp
// side does not stall. It then yields sixteen channel words, channel 0 first,
// the last one marked. A bad footer drops the frame without output. Registers
// may be written only while the block is idle; csr_ready is always high and
// unused indexes are ignored.
module rc_servo_frame_decoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcsfd_pkg::CHAN_IDX_W-1:0]     rsp_chan_index,
   output logic [rcsfd_pkg::CHAN_W-1:0]         rsp_chan_value,
   output logic                                 rsp_lost_frame,
   output logic                                 rsp_failsafe_on,
   output logic                                 rsp_last_of_frame,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rcsfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                           csr_wdata
);
   import rcsfd_pkg::*;

   typedef enum logic [3:0] {
      ST_HUNT   = 4'b0001,
      ST_BODY   = 4'b0010,
      ST_FLAGS  = 4'b0100,
      ST_UNPACK = 4'b1000
   } state_type;

   function automatic logic footer_match(input logic [7:0] b, input logic [7:0] plain,
                                         input logic [7:0] mask, input logic [7:0] value);
      return (b == plain) || ((b & mask) == value);
   endfunction

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]        prev_ff, prev_in;

   logic [7:0] header_ff, footer_ff, alt_mask_ff, alt_value_ff, lost_mask_ff, safe_mask_ff;

   logic              req_accept;
   logic              csr_write;
   logic              prev_is_footer;
   logic              rx_is_footer;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   unp_ctrl_type      unp_ctrl;
   unp_stat_type      unp_stat;

   assign req_stall  = ~((state_ff == ST_HUNT) || (state_ff == ST_BODY));
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;

   assign prev_is_footer = footer_match(prev_ff, footer_ff, alt_mask_ff, alt_value_ff);
   assign rx_is_footer   = footer_match(req_rx_byte, footer_ff, alt_mask_ff, alt_value_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= 8'h0F;
         footer_ff    <= 8'h00;
         alt_mask_ff  <= 8'h0F;
         alt_value_ff <= 8'h04;
         lost_mask_ff <= 8'h04;
         safe_mask_ff <= 8'h08;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HEADER:    header_ff    <= csr_wdata;
            REG_FOOTER:    footer_ff    <= csr_wdata;
            REG_ALT_MASK:  alt_mask_ff  <= csr_wdata;
            REG_ALT_VALUE: alt_value_ff <= csr_wdata;
            REG_LOST_MASK: lost_mask_ff <= csr_wdata;
            REG_SAFE_MASK: safe_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame sequencer
   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      rd_idx_in = rd_idx_ff;
      prev_in   = prev_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rd_idx_ff;
      unp_ctrl  = '0;
      unp_ctrl.lost = |(rd_data & lost_mask_ff);
      unp_ctrl.safe = |(rd_data & safe_mask_ff);
      if (req_accept) begin
         prev_in = req_rx_byte;
      end
      unique case (state_ff)
         ST_HUNT: begin
            if (req_accept && (req_rx_byte == header_ff) && prev_is_footer) begin
               state_in = ST_BODY;
               slot_in  = '0;
            end
         end
         ST_BODY: begin
            if (req_accept) begin
               wr_en = 1'b1;
               if (slot_ff == LAST_SLOT) begin
                  if (rx_is_footer) begin
                     state_in = ST_FLAGS;
                     rd_en    = 1'b1;
                     rd_addr  = FLAGS_ADDR;
                  end else begin
                     state_in = ST_HUNT;
                  end
               end else begin
                  slot_in = slot_ff + 5'd1;
               end
            end
         end
         ST_FLAGS: begin
            unp_ctrl.clear = 1'b1;
            rd_en          = 1'b1;
            rd_addr        = '0;
            rd_idx_in      = '0;
            state_in       = ST_UNPACK;
         end
         ST_UNPACK: begin
            if (unp_stat.byte_ready) begin
               unp_ctrl.byte_valid = 1'b1;
               if (rd_idx_ff == LAST_DATA_ADDR) begin
                  state_in = ST_HUNT;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = rd_idx_ff + 5'd1;
                  rd_idx_in = rd_idx_ff + 5'd1;
               end
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         slot_ff   <= '0;
         rd_idx_ff <= '0;
         prev_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         rd_idx_ff <= rd_idx_in;
         prev_ff   <= prev_in;
      end
   end

   rcsfd_frame_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcsfd_unpacker u_unpacker (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (unp_ctrl),
      .byte_data         (rd_data),
      .stat              (unp_stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chan_index    (rsp_chan_index),
      .rsp_chan_value    (rsp_chan_value),
      .rsp_lost_frame    (rsp_lost_frame),
      .rsp_failsafe_on   (rsp_failsafe_on),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

/* rtl/rcsfd_frame_store.sv */
`default_nettype none

module rcsfd_frame_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [rcsfd_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [rcsfd_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                    rd_data
);
   import rcsfd_pkg::*;

   logic [7:0] mem_ff [0:BODY_BYTES-1];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/rcsfd_unpacker.sv */
`default_nettype none

module rcsfd_unpacker (
   input  logic                               clock,
   input  logic                               reset,
   input  rcsfd_pkg::unp_ctrl_type            ctrl,
   input  logic [7:0]                         byte_data,
   output rcsfd_pkg::unp_stat_type            stat,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rcsfd_pkg::CHAN_IDX_W-1:0]   rsp_chan_index,
   output logic [rcsfd_pkg::CHAN_W-1:0]       rsp_chan_value,
   output logic                               rsp_lost_frame,
   output logic                               rsp_failsafe_on,
   output logic                               rsp_last_of_frame
);
   import rcsfd_pkg::*;

   // bit accumulator: at most ten bits wait between bytes
   logic [9:0]            acc_ff, acc_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [CHAN_IDX_W-1:0] chan_ff, chan_in;
   logic                  lost_ff, lost_in;
   logic                  safe_ff, safe_in;

   logic                  out_valid_ff, out_valid_in;
   logic [CHAN_IDX_W-1:0] out_index_ff;
   logic [CHAN_W-1:0]     out_value_ff;
   logic                  out_lost_ff;
   logic                  out_safe_ff;
   logic                  out_last_ff;

   logic [17:0] merged;
   logic [4:0]  cnt_sum;
   logic        emit;
   logic        out_free;
   logic        load;

   // merge the new byte above the bits already held
   assign merged   = {8'd0, acc_ff} | ({10'd0, byte_data} << cnt_ff);
   assign cnt_sum  = {1'b0, cnt_ff} + 5'd8;
   assign emit     = (cnt_sum >= 5'(CHAN_W));
   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign load     = ctrl.byte_valid & emit;

   assign stat.byte_ready = ~emit | out_free;

   // accumulator and channel counter
   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      chan_in = chan_ff;
      lost_in = lost_ff;
      safe_in = safe_ff;
      if (ctrl.clear) begin
         acc_in  = '0;
         cnt_in  = '0;
         chan_in = '0;
         lost_in = ctrl.lost;
         safe_in = ctrl.safe;
      end else if (ctrl.byte_valid) begin
         if (emit) begin
            acc_in  = {3'd0, merged[17:11]};
            cnt_in  = 4'(cnt_sum - 5'(CHAN_W));
            chan_in = chan_ff + 4'd1;
         end else begin
            acc_in = merged[9:0];
            cnt_in = cnt_sum[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         chan_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      lost_ff <= lost_in;
      safe_ff <= safe_in;
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      if (load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_index_ff <= chan_ff;
         out_value_ff <= merged[CHAN_W-1:0];
         out_lost_ff  <= lost_ff;
         out_safe_ff  <= safe_ff;
         out_last_ff  <= (chan_ff == LAST_CHAN);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_chan_index    = out_index_ff;
   assign rsp_chan_value    = out_value_ff;
   assign rsp_lost_frame    = out_lost_ff;
   assign rsp_failsafe_on   = out_safe_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

`default_nettype wire

/* rtl/rcsfd_checker.sv */
`default_nettype none

module rcsfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_chan_index,
   input logic [10:0] rsp_chan_value,
   input logic        rsp_last_of_frame
);

   // a stalled word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp word withdrawn while stalled");

   // a stalled word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_chan_index) && $stable(rsp_chan_value))
      else $error("rsp payload changed while stalled");

   // the end marker sits on the sixteenth channel only
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_frame == (rsp_chan_index == 4'd15)))
      else $error("end-of-frame marker on wrong channel");

   // no new byte is taken while a frame is still being unpacked
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_frame |-> req_stall)
      else $error("req open while frame still draining");

endmodule

bind rc_servo_frame_decoder_unit rcsfd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_chan_index    (rsp_chan_index),
   .rsp_chan_value    (rsp_chan_value),
   .rsp_last_of_frame (rsp_last_of_frame)
);

`default_nettype wire
